>>> rtl/tdt_pkg.sv
// ----------------------------------------------------------------------------
// tdt_pkg: shared types and constants for the thermistor temperature converter
// Widths, register indexes, status codes, fixed-point constants and the
// log2 table generator used at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package tdt_pkg;

    // Defaults for top-level parameters
    localparam int LOG_TABLE_BITS_DEF  = 8;
    localparam int COEFF_FRAC_BITS_DEF = 40;

    // Field and register widths
    localparam int VOLT_W     = 23;
    localparam int OHM_W      = 20;
    localparam int COEFF_W    = 40;
    localparam int TEMP_W     = 16;
    localparam int STAT_W     = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 40;
    localparam int IN_DATA_W  = 24;

    // Internal fixed-point widths
    localparam int R_FRAC     = 16;
    localparam int NORM_W     = 64;
    localparam int TAB_W      = 31;
    localparam int LG2_W      = 38;
    localparam int L1_W       = 37;
    localparam int L2_W       = 42;
    localparam int L3_W       = 47;
    localparam int BL1_W      = 47;
    localparam int CL3_W      = 57;
    localparam int TINV_W     = 57;
    localparam int DEN2_W     = 56;
    localparam int DIV1_NUM_W = OHM_W + VOLT_W + R_FRAC;
    localparam int LN2_W      = 63;
    localparam int Q_SHIFT    = 30;

    // ln(2) in Q62
    localparam logic signed [LN2_W-1:0] LN2_Q62 = 63'sh2C5C85FDF473DE6B;

    // Output range and Kelvin offset in centidegrees
    localparam int CENTI_OFS = 27315;
    localparam int Q_HI      = 47315;
    localparam int Q_LO      = 19315;
    localparam logic signed [TEMP_W-1:0] TEMP_HI = 16'sd20000;
    localparam logic signed [TEMP_W-1:0] TEMP_LO = -16'sd8000;

    // Register reset values
    localparam logic signed [COEFF_W-1:0] COEFF_A_RST = 40'sd1129148416;
    localparam logic signed [COEFF_W-1:0] COEFF_B_RST = 40'sd257894400;
    localparam logic signed [COEFF_W-1:0] COEFF_C_RST = 40'sd96600;
    localparam logic [OHM_W-1:0]          DIVIDER_RST = 20'd6200;
    localparam logic [VOLT_W-1:0]         SUPPLY_RST  = 23'd3300000;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_COEFF_A = 3'd0,
        CFG_COEFF_B = 3'd1,
        CFG_COEFF_C = 3'd2,
        CFG_DIVIDER = 3'd3,
        CFG_SUPPLY  = 3'd4
    } t_cfg_idx;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_OPEN  = 2'd1,
        ST_SHORT = 2'd2,
        ST_CLAMP = 2'd3
    } t_status;

    // Per-item flags that travel down the pipeline
    typedef struct packed {
        logic valid;
        logic open;
        logic shorted;
    } t_flags;

    // Flags ahead of the reciprocal divider
    typedef struct packed {
        t_flags fl;
        logic   zero;
        logic   neg;
    } t_rcp_flags;

    // log2 of (1 + idx/2^bits) in Q30, fraction bits by repeated squaring
    function automatic logic [TAB_W-1:0] log2_entry(input int idx, input int bits);
        logic [63:0]      y;
        logic [TAB_W-1:0] r;
        int               k;
        y = (64'd1 << 30) + (64'(idx) << (30 - bits));
        r = '0;
        if (idx == (1 << bits)) begin
            r = TAB_W'(64'd1 << 30);
        end else begin
            for (k = 29; k >= 0; k--) begin
                y = (y * y) >> 30;
                if (y >= (64'd1 << 31)) begin
                    y    = y >> 1;
                    r[k] = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/thermistor_divider_to_temperature.sv
// ----------------------------------------------------------------------------
// thermistor_divider_to_temperature: NTC divider voltage to centidegrees C
// Throughput: one transaction per cycle; the pipeline holds as a whole only
// while a result waits in the output register and the pipeline tail is full.
// The pipeline depth is set by the two restoring dividers (59 and 57 stages)
// plus the log unit (9) and four multipliers in series (4 each).
// Reset (synchronous, active low) clears all valid bits and loads the
// register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module thermistor_divider_to_temperature #(
    parameter int LOG_TABLE_BITS  = tdt_pkg::LOG_TABLE_BITS_DEF,
    parameter int COEFF_FRAC_BITS = tdt_pkg::COEFF_FRAC_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [tdt_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [tdt_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [tdt_pkg::IN_DATA_W-1:0]    s_tdata,   // [22:0] node_microvolts
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [tdt_pkg::TEMP_W-1:0]            m_tdata,   // [15:0] temp_centi_celsius
    output logic [tdt_pkg::STAT_W-1:0]            m_tuser    // [1:0] status
);

    localparam int VW    = tdt_pkg::VOLT_W;
    localparam int NUM_W = tdt_pkg::OHM_W + tdt_pkg::VOLT_W;
    localparam int NUM2_W = ((7 + COEFF_FRAC_BITS > tdt_pkg::DEN2_W)
                            ? 7 + COEFF_FRAC_BITS : tdt_pkg::DEN2_W) + 1;
    localparam int TV    = tdt_pkg::TINV_W;

    // Configuration registers
    logic signed [tdt_pkg::COEFF_W-1:0] r_coeff_a, r_coeff_b, r_coeff_c;
    logic [tdt_pkg::OHM_W-1:0]          r_divider;
    logic [VW-1:0]                      r_supply;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff_a <= tdt_pkg::COEFF_A_RST;
            r_coeff_b <= tdt_pkg::COEFF_B_RST;
            r_coeff_c <= tdt_pkg::COEFF_C_RST;
            r_divider <= tdt_pkg::DIVIDER_RST;
            r_supply  <= tdt_pkg::SUPPLY_RST;
        end else if (i_cfg_we) begin
            unique case (tdt_pkg::t_cfg_idx'(i_cfg_addr))
                tdt_pkg::CFG_COEFF_A: r_coeff_a <= $signed(i_cfg_wdata);
                tdt_pkg::CFG_COEFF_B: r_coeff_b <= $signed(i_cfg_wdata);
                tdt_pkg::CFG_COEFF_C: r_coeff_c <= $signed(i_cfg_wdata);
                tdt_pkg::CFG_DIVIDER: r_divider <= i_cfg_wdata[tdt_pkg::OHM_W-1:0];
                tdt_pkg::CFG_SUPPLY:  r_supply  <= i_cfg_wdata[VW-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline advance: move unless a result waits and the tail is full
    logic                  w_adv;
    logic                  r_out_vld;
    tdt_pkg::t_rcp_flags   w_d2_side;

    assign w_adv    = ~r_out_vld | m_tready | ~w_d2_side.fl.valid;
    assign s_tready = w_adv;

    // Input register
    logic          r_in_vld;
    logic [VW-1:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_adv) begin
            r_in_vld <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_v <= s_tdata[VW-1:0];
        end
    end

    // Open check, divider numerator and denominator
    tdt_pkg::t_flags  r_s1_fl;
    logic [NUM_W-1:0] r_num;
    logic [VW-1:0]    r_den;
    logic             w_open;

    assign w_open = (r_v >= r_supply);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_fl <= '0;
        end else if (w_adv) begin
            r_s1_fl.valid   <= r_in_vld;
            r_s1_fl.open    <= w_open;
            r_s1_fl.shorted <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_num <= r_divider * r_v;
            r_den <= w_open ? VW'(1) : r_supply - r_v;
        end
    end

    // Resistance in Q16
    logic [tdt_pkg::DIV1_NUM_W-1:0] w_rq;
    tdt_pkg::t_flags                w_d1_fl;

    tdt_div #(
        .NUM_W (tdt_pkg::DIV1_NUM_W),
        .DEN_W (VW),
        .SW    ($bits(tdt_pkg::t_flags))
    ) u_div_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_num   ({r_num, {tdt_pkg::R_FRAC{1'b0}}}),
        .i_den   (r_den),
        .i_side  (r_s1_fl),
        .o_quot  (w_rq),
        .o_side  (w_d1_fl)
    );

    // Flag a short on a zero resistance
    tdt_pkg::t_flags w_log_in;
    always_comb begin
        w_log_in         = w_d1_fl;
        w_log_in.shorted = (w_rq == '0);
    end

    logic signed [tdt_pkg::LG2_W-1:0] w_lg2;
    tdt_pkg::t_flags                  w_log_fl;

    tdt_log #(
        .LOG_TABLE_BITS (LOG_TABLE_BITS),
        .SW             ($bits(tdt_pkg::t_flags))
    ) u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_x     (tdt_pkg::NORM_W'(w_rq)),
        .i_side  (w_log_in),
        .o_lg2   (w_lg2),
        .o_side  (w_log_fl)
    );

    // lnR = log2 * ln2
    logic signed [tdt_pkg::L1_W-1:0] w_l1;
    tdt_pkg::t_flags                 w_l_fl;

    tdt_mulsh #(
        .AW (tdt_pkg::LG2_W), .BW (tdt_pkg::LN2_W), .SH (62),
        .OW (tdt_pkg::L1_W),  .SW ($bits(tdt_pkg::t_flags))
    ) u_mul_ln (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_adv),
        .i_a (w_lg2), .i_b (tdt_pkg::LN2_Q62), .i_side (w_log_fl),
        .o_p (w_l1), .o_side (w_l_fl)
    );

    // lnR^2, carrying lnR alongside
    localparam int M1_SW = $bits(tdt_pkg::t_flags) + tdt_pkg::L1_W;
    logic signed [tdt_pkg::L2_W-1:0] w_l2;
    logic [M1_SW-1:0]                w_m1_side;
    tdt_pkg::t_flags                 w_m1_fl;
    logic signed [tdt_pkg::L1_W-1:0] w_l1d;

    tdt_mulsh #(
        .AW (tdt_pkg::L1_W), .BW (tdt_pkg::L1_W), .SH (tdt_pkg::Q_SHIFT),
        .OW (tdt_pkg::L2_W), .SW (M1_SW)
    ) u_mul_sq (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_adv),
        .i_a (w_l1), .i_b (w_l1), .i_side ({w_l_fl, w_l1}),
        .o_p (w_l2), .o_side (w_m1_side)
    );

    assign w_m1_fl = w_m1_side[M1_SW-1 -: $bits(tdt_pkg::t_flags)];
    assign w_l1d   = $signed(w_m1_side[tdt_pkg::L1_W-1:0]);

    // lnR^3 and B*lnR in parallel
    logic signed [tdt_pkg::L3_W-1:0]  w_l3;
    tdt_pkg::t_flags                  w_m2_fl;
    logic signed [tdt_pkg::BL1_W-1:0] w_bl1;
    logic                             w_m2b_vld;

    tdt_mulsh #(
        .AW (tdt_pkg::L2_W), .BW (tdt_pkg::L1_W), .SH (tdt_pkg::Q_SHIFT),
        .OW (tdt_pkg::L3_W), .SW ($bits(tdt_pkg::t_flags))
    ) u_mul_cube (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_adv),
        .i_a (w_l2), .i_b (w_l1d), .i_side (w_m1_fl),
        .o_p (w_l3), .o_side (w_m2_fl)
    );

    tdt_mulsh #(
        .AW (tdt_pkg::L1_W),  .BW (tdt_pkg::COEFF_W), .SH (tdt_pkg::Q_SHIFT),
        .OW (tdt_pkg::BL1_W), .SW (1)
    ) u_mul_b (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_adv),
        .i_a (w_l1d), .i_b (r_coeff_b), .i_side (w_m1_fl.valid),
        .o_p (w_bl1), .o_side (w_m2b_vld)
    );

    // C*lnR^3, carrying B*lnR alongside
    localparam int M3_SW = $bits(tdt_pkg::t_flags) + tdt_pkg::BL1_W;
    logic signed [tdt_pkg::CL3_W-1:0] w_cl3;
    logic [M3_SW-1:0]                 w_m3_side;
    tdt_pkg::t_flags                  w_m3_fl;
    logic signed [tdt_pkg::BL1_W-1:0] w_bl1d;

    tdt_mulsh #(
        .AW (tdt_pkg::L3_W),  .BW (tdt_pkg::COEFF_W), .SH (tdt_pkg::Q_SHIFT),
        .OW (tdt_pkg::CL3_W), .SW (M3_SW)
    ) u_mul_c (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_adv),
        .i_a (w_l3), .i_b (r_coeff_c), .i_side ({w_m2_fl, w_bl1}),
        .o_p (w_cl3), .o_side (w_m3_side)
    );

    assign w_m3_fl = w_m3_side[M3_SW-1 -: $bits(tdt_pkg::t_flags)];
    assign w_bl1d  = $signed(w_m3_side[tdt_pkg::BL1_W-1:0]);

    // 1/T = A + B*lnR + C*lnR^3
    logic signed [TV-1:0] r_tinv;
    tdt_pkg::t_flags      r_add_fl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add_fl <= '0;
        end else if (w_adv) begin
            r_add_fl <= w_m3_fl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tinv <= TV'(r_coeff_a) + TV'(w_bl1d) + TV'(w_cl3);
        end
    end

    // Rounded reciprocal operands: (100 * 2^F + 1/T / 2) / (1/T)
    tdt_pkg::t_rcp_flags          r_rcp_fl;
    logic [NUM2_W-1:0]            r_num2;
    logic [tdt_pkg::DEN2_W-1:0]   r_den2;
    logic                         w_tz, w_tn;

    assign w_tz = (r_tinv == '0);
    assign w_tn = r_tinv[TV-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rcp_fl <= '0;
        end else if (w_adv) begin
            r_rcp_fl.fl   <= r_add_fl;
            r_rcp_fl.zero <= w_tz;
            r_rcp_fl.neg  <= w_tn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_num2 <= (NUM2_W'(100) << COEFF_FRAC_BITS) + NUM2_W'(r_tinv[TV-2:1]);
            r_den2 <= (w_tz | w_tn) ? tdt_pkg::DEN2_W'(1) : r_tinv[tdt_pkg::DEN2_W-1:0];
        end
    end

    logic [NUM2_W-1:0] w_q;

    tdt_div #(
        .NUM_W (NUM2_W),
        .DEN_W (tdt_pkg::DEN2_W),
        .SW    ($bits(tdt_pkg::t_rcp_flags))
    ) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_num   (r_num2),
        .i_den   (r_den2),
        .i_side  (r_rcp_fl),
        .o_quot  (w_q),
        .o_side  (w_d2_side)
    );

    // Kelvin offset, clamp and status
    logic signed [tdt_pkg::TEMP_W-1:0] w_temp;
    tdt_pkg::t_status                  w_status;

    always_comb begin
        w_temp   = $signed(w_q[tdt_pkg::TEMP_W-1:0] - tdt_pkg::TEMP_W'(tdt_pkg::CENTI_OFS));
        w_status = tdt_pkg::ST_OK;
        priority if (w_d2_side.fl.open) begin
            w_temp   = '0;
            w_status = tdt_pkg::ST_OPEN;
        end else if (w_d2_side.fl.shorted) begin
            w_temp   = '0;
            w_status = tdt_pkg::ST_SHORT;
        end else if (w_d2_side.zero) begin
            w_temp   = tdt_pkg::TEMP_HI;
            w_status = tdt_pkg::ST_CLAMP;
        end else if (w_d2_side.neg) begin
            w_temp   = tdt_pkg::TEMP_LO;
            w_status = tdt_pkg::ST_CLAMP;
        end else if (w_q > NUM2_W'(tdt_pkg::Q_HI)) begin
            w_temp   = tdt_pkg::TEMP_HI;
            w_status = tdt_pkg::ST_CLAMP;
        end else if (w_q < NUM2_W'(tdt_pkg::Q_LO)) begin
            w_temp   = tdt_pkg::TEMP_LO;
            w_status = tdt_pkg::ST_CLAMP;
        end else begin
            w_status = tdt_pkg::ST_OK;
        end
    end

    // Output register
    logic                 w_out_free;
    assign w_out_free = ~r_out_vld | m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= w_d2_side.fl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            m_tdata <= w_temp;
            m_tuser <= w_status;
        end
    end

    assign m_tvalid = r_out_vld;

    // Checks
    a_open_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (m_tuser == tdt_pkg::ST_OPEN || m_tuser == tdt_pkg::ST_SHORT))
        |-> (m_tdata == '0))
        else $error("open or short result carries a nonzero temperature");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> ($signed(m_tdata) >= tdt_pkg::TEMP_LO &&
                      $signed(m_tdata) <= tdt_pkg::TEMP_HI))
        else $error("temperature outside the output range");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> (r_out_vld && !m_tready && w_d2_side.fl.valid))
        else $error("input held off without a blocked result");

    a_mul_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_m2b_vld == w_m2_fl.valid)
        else $error("parallel multiplier lanes out of step");

    a_tail_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_d2_side.fl.valid && !w_adv) |=> w_d2_side.fl.valid)
        else $error("stalled pipeline tail lost its item");

endmodule

`default_nettype wire

>>> rtl/tdt_div.sv
// ----------------------------------------------------------------------------
// tdt_div: pipelined restoring divider
// One quotient bit per stage, MSB first; a sideband word rides with each item.
// ----------------------------------------------------------------------------
`default_nettype none

module tdt_div #(
    parameter int NUM_W = 59,
    parameter int DEN_W = 23,
    parameter int SW    = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [SW-1:0]    i_side,
    output logic      [NUM_W-1:0] o_quot,
    output logic      [SW-1:0]    o_side
);

    logic [DEN_W-1:0] r_rem  [NUM_W];
    logic [NUM_W-1:0] r_nq   [NUM_W];
    logic [DEN_W-1:0] r_den  [NUM_W];
    logic [SW-1:0]    r_side [NUM_W];

    genvar k;
    generate
        for (k = 0; k < NUM_W; k++) begin : g_stage
            logic [DEN_W-1:0] w_rem_in;
            logic [NUM_W-1:0] w_nq_in;
            logic [DEN_W-1:0] w_den_in;
            logic [SW-1:0]    w_side_in;
            logic [DEN_W:0]   w_trial;
            logic [DEN_W:0]   w_diff;
            logic             w_ge;

            if (k == 0) begin : g_first
                assign w_rem_in  = '0;
                assign w_nq_in   = i_num;
                assign w_den_in  = i_den;
                assign w_side_in = i_side;
            end else begin : g_next
                assign w_rem_in  = r_rem[k-1];
                assign w_nq_in   = r_nq[k-1];
                assign w_den_in  = r_den[k-1];
                assign w_side_in = r_side[k-1];
            end

            // Shift in the next dividend bit and try the subtract
            assign w_trial = {w_rem_in, w_nq_in[NUM_W-1]};
            assign w_diff  = w_trial - {1'b0, w_den_in};
            assign w_ge    = (w_trial >= {1'b0, w_den_in});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_side[k] <= '0;
                end else if (i_en) begin
                    r_side[k] <= w_side_in;
                end
            end

            // Restore on a failed subtract, shift the quotient bit in
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                    r_nq[k]  <= {w_nq_in[NUM_W-2:0], w_ge};
                    r_den[k] <= w_den_in;
                end
            end
        end
    endgenerate

    assign o_quot = r_nq[NUM_W-1];
    assign o_side = r_side[NUM_W-1];

endmodule

`default_nettype wire

>>> rtl/tdt_log.sv
// ----------------------------------------------------------------------------
// tdt_log: pipelined base-2 logarithm
// Normalizes in six shift stages, reads an interpolated log2 table and gives
// log2 of x / 2^16 in signed Q30.
// ----------------------------------------------------------------------------
`default_nettype none

module tdt_log #(
    parameter int LOG_TABLE_BITS = tdt_pkg::LOG_TABLE_BITS_DEF,
    parameter int SW             = 3
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic [tdt_pkg::NORM_W-1:0]      i_x,
    input  wire logic [SW-1:0]                   i_side,
    output logic signed [tdt_pkg::LG2_W-1:0]     o_lg2,
    output logic [SW-1:0]                        o_side
);

    localparam int NSTG  = 6;
    localparam int SH_W  = 32 - LOG_TABLE_BITS;
    localparam int TAB_N = (1 << LOG_TABLE_BITS) + 1;
    localparam int TI_W  = LOG_TABLE_BITS + 1;
    localparam int XW    = tdt_pkg::NORM_W;
    localparam int TW    = tdt_pkg::TAB_W;

    logic [XW-1:0] r_x  [NSTG];
    logic [5:0]    r_lz [NSTG];
    logic [SW-1:0] r_sd [NSTG];

    // Normalize: shift out leading zeros by 32, 16, 8, 4, 2, 1
    genvar j;
    generate
        for (j = 0; j < NSTG; j++) begin : g_norm
            localparam int S = 32 >> j;
            logic [XW-1:0] w_x_in;
            logic [5:0]    w_lz_in;
            logic [SW-1:0] w_sd_in;
            logic          w_zero;

            if (j == 0) begin : g_first
                assign w_x_in  = i_x;
                assign w_lz_in = '0;
                assign w_sd_in = i_side;
            end else begin : g_next
                assign w_x_in  = r_x[j-1];
                assign w_lz_in = r_lz[j-1];
                assign w_sd_in = r_sd[j-1];
            end

            assign w_zero = (w_x_in[XW-1 -: S] == '0);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sd[j] <= '0;
                end else if (i_en) begin
                    r_sd[j] <= w_sd_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[j]  <= w_zero ? (w_x_in << S) : w_x_in;
                    r_lz[j] <= w_lz_in + (w_zero ? 6'(S) : 6'd0);
                end
            end
        end
    endgenerate

    // Constant log2 table, one entry past the end for interpolation
    logic [TW-1:0] w_tab [TAB_N];
    genvar t;
    generate
        for (t = 0; t < TAB_N; t++) begin : g_tab
            assign w_tab[t] = tdt_pkg::log2_entry(t, LOG_TABLE_BITS);
        end
    endgenerate

    logic [31:0]     w_f;
    logic [TI_W-1:0] w_idx0;
    logic [TI_W-1:0] w_idx1;
    logic [5:0]      w_e;

    assign w_f    = r_x[NSTG-1][62:31];
    assign w_idx0 = {1'b0, w_f[31 -: LOG_TABLE_BITS]};
    assign w_idx1 = w_idx0 + TI_W'(1);
    assign w_e    = 6'd63 - r_lz[NSTG-1];

    // Table read stage
    logic [TW-1:0]   r_base_t;
    logic [TW-1:0]   r_diff_t;
    logic [SH_W-1:0] r_rem_t;
    logic [5:0]      r_e_t;
    logic [SW-1:0]   r_sd_t;

    // Interpolation product stage
    logic [TW+SH_W-1:0] r_prod_p;
    logic [TW-1:0]      r_base_p;
    logic [5:0]         r_e_p;
    logic [SW-1:0]      r_sd_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd_t <= '0;
            r_sd_p <= '0;
            o_side <= '0;
        end else if (i_en) begin
            r_sd_t <= r_sd[NSTG-1];
            r_sd_p <= r_sd_t;
            o_side <= r_sd_p;
        end
    end

    logic [TW-1:0]                   w_interp;
    logic signed [6:0]               w_ip;
    logic signed [tdt_pkg::LG2_W-1:0] w_lg2;

    // Integer part is exponent minus the Q16 point, fraction from table
    assign w_interp = r_base_p + r_prod_p[SH_W +: TW];
    assign w_ip     = $signed({1'b0, r_e_p}) - 7'sd16;
    assign w_lg2    = tdt_pkg::LG2_W'($signed({w_ip, 30'b0}))
                    + tdt_pkg::LG2_W'($signed({1'b0, w_interp}));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_base_t <= w_tab[w_idx0];
            r_diff_t <= w_tab[w_idx1] - w_tab[w_idx0];
            r_rem_t  <= w_f[SH_W-1:0];
            r_e_t    <= w_e;
            r_prod_p <= r_diff_t * r_rem_t;
            r_base_p <= r_base_t;
            r_e_p    <= r_e_t;
            o_lg2    <= w_lg2;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tdt_mulsh.sv
// ----------------------------------------------------------------------------
// tdt_mulsh: pipelined signed multiply with right shift
// Sign-magnitude form, four half-width partial products, magnitude truncated
// after the shift so the result rounds toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tdt_mulsh #(
    parameter int AW = 38,
    parameter int BW = 63,
    parameter int SH = 62,
    parameter int OW = 37,
    parameter int SW = 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic signed [AW-1:0] i_a,
    input  wire logic signed [BW-1:0] i_b,
    input  wire logic [SW-1:0]        i_side,
    output logic signed [OW-1:0]      o_p,
    output logic [SW-1:0]             o_side
);

    localparam int AL = AW / 2;
    localparam int AH = AW - AL;
    localparam int BL = BW / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;
    localparam int MW = OW - 1;

    logic [SW-1:0] r_sd1, r_sd2, r_sd3;
    logic          r_neg1, r_neg2, r_neg3;
    logic [AW-1:0] r_ma;
    logic [BW-1:0] r_mb;
    logic [AL+BL-1:0] r_ll;
    logic [AL+BH-1:0] r_lh;
    logic [AH+BL-1:0] r_hl;
    logic [AH+BH-1:0] r_hh;
    logic [MW-1:0]    r_mag;
    logic [PW-1:0]    w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd1  <= '0;
            r_sd2  <= '0;
            r_sd3  <= '0;
            o_side <= '0;
        end else if (i_en) begin
            r_sd1  <= i_side;
            r_sd2  <= r_sd1;
            r_sd3  <= r_sd2;
            o_side <= r_sd3;
        end
    end

    // Recombine partial products and drop the fraction
    assign w_sum = (PW'(r_hh) << (AL + BL)) + (PW'(r_lh) << BL)
                 + (PW'(r_hl) << AL) + PW'(r_ll);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Magnitudes and result sign
            r_neg1 <= i_a[AW-1] ^ i_b[BW-1];
            r_ma   <= i_a[AW-1] ? AW'(-i_a) : AW'(i_a);
            r_mb   <= i_b[BW-1] ? BW'(-i_b) : BW'(i_b);
            // Partial products
            r_neg2 <= r_neg1;
            r_ll   <= r_ma[AL-1:0]  * r_mb[BL-1:0];
            r_lh   <= r_ma[AL-1:0]  * r_mb[BW-1:BL];
            r_hl   <= r_ma[AW-1:AL] * r_mb[BL-1:0];
            r_hh   <= r_ma[AW-1:AL] * r_mb[BW-1:BL];
            // Shifted magnitude
            r_neg3 <= r_neg2;
            r_mag  <= w_sum[SH +: MW];
            // Reapply sign
            o_p    <= r_neg3 ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
        end
    end

endmodule

`default_nettype wire
